// ===== hdl/tkls_pkg.sv =====
// Package for the top-K selector: payload types, neighbour link type and defaults.
`default_nettype none

package tkls_pkg;

  // Default number of values held per set
  localparam int unsigned TOP_K_DEFAULT = 5;

  // Width of a data value and of the emitted rank
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 3;

  // One input item
  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      end_of_set;
  } in_t;

  // One result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic [RANK_W-1:0]         rank_position;
    logic                      final_result;
  } out_t;

  // What a cell hands to its right-hand neighbour each cycle
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    logic                      keep;
  } link_t;

endpackage : tkls_pkg

`default_nettype wire

// ===== hdl/tkls_cell.sv =====
// One cell of the sorted chain: a held value plus one slot of the result shift line.
`default_nettype none

module tkls_cell (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   insert,
  input  wire logic                                   clear_row,
  input  wire logic signed [tkls_pkg::VALUE_W-1:0]    sample,
  input  wire tkls_pkg::link_t                        link_in,
  output tkls_pkg::link_t                             link_out,
  input  wire logic                                   buf_load,
  input  wire logic                                   buf_shift,
  input  wire logic signed [tkls_pkg::VALUE_W-1:0]    buf_in,
  output logic signed [tkls_pkg::VALUE_W-1:0]         buf_out,
  output logic                                        valid_next,
  output logic                                        valid_q
);

  import tkls_pkg::*;

  logic signed [VALUE_W-1:0] value;
  logic                      valid;
  logic                      keep;
  logic signed [VALUE_W-1:0] cand_value;
  logic                      cand_valid;
  logic signed [VALUE_W-1:0] value_next;
  logic signed [VALUE_W-1:0] out_value;

  // Hold our value if it is at least the sample (ties stay ahead of the new copy)
  assign keep = valid && (value >= sample);

  assign link_out = '{value: value, valid: valid, keep: keep};

  // Take the sample if the left neighbour holds, otherwise take its value
  always_comb begin
    if (link_in.keep) begin
      cand_value = sample;
      cand_valid = 1'b1;
    end else begin
      cand_value = link_in.value;
      cand_valid = link_in.valid;
    end
    if (keep) begin
      value_next = value;
      valid_next = valid;
    end else begin
      value_next = cand_value;
      valid_next = cand_valid;
    end
  end

  // Advance the held value; drop the whole row at the end of a set
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (insert) begin
      valid <= clear_row ? 1'b0 : valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      value <= value_next;
    end
  end

  // Result slot: capture the final ordering, then shift toward the output
  always_ff @(posedge clk) begin
    if (buf_load) begin
      out_value <= value_next;
    end else if (buf_shift) begin
      out_value <= buf_in;
    end
  end

  assign buf_out = out_value;
  assign valid_q = valid;

endmodule : tkls_cell

`default_nettype wire

// ===== hdl/top_k_largest_selector.sv =====
// Top level of the streaming top-K selector: the cell chain and the result drain.
`default_nettype none

// Takes one signed value per cycle while in_ready is high and keeps the TOP_K largest of
// the current set in a chain of compare cells, largest in the leftmost cell; every cell
// compares against the new value in parallel, so insertion takes no longer for a larger
// TOP_K. On the value marked end_of_set the final ordering is copied into a result shift
// line and the chain is cleared, so the next set streams in straight away. Results leave
// one per cycle while out_ready is high, largest first, rank_position counting from 0
// (low 3 bits) and final_result on the last. A set emits min(set length, TOP_K) results.
// An end_of_set item is held off until the result line is empty or its last result
// leaves on the same edge.

module top_k_largest_selector #(
  parameter int unsigned TOP_K = tkls_pkg::TOP_K_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tkls_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tkls_pkg::out_t     out_data
);

  import tkls_pkg::*;

  localparam int unsigned CW = $clog2(TOP_K + 1);

  logic                      in_fire;
  logic                      out_fire;
  logic                      load;
  logic                      buf_free;
  logic [CW-1:0]             buf_count;
  logic [CW-1:0]             buf_count_next;
  logic [RANK_W-1:0]         rank;
  logic [TOP_K-1:0]          nvalid;
  logic [TOP_K-1:0]          cell_valid;
  link_t                     links [TOP_K+1];
  logic signed [VALUE_W-1:0] bufs  [TOP_K+1];

  // Result line is free for a new set when empty or its last result leaves now
  assign out_fire = out_valid && out_ready;
  assign buf_free = (buf_count == '0) || ((buf_count == CW'(1)) && out_ready);
  assign in_ready = !in_data.end_of_set || buf_free;
  assign in_fire  = in_valid && in_ready;
  assign load     = in_fire && in_data.end_of_set;

  // Virtual cell left of the chain always holds, so cell 0 sees the sample first
  assign links[0] = '{value: '0, valid: 1'b0, keep: 1'b1};
  assign bufs[TOP_K] = bufs[TOP_K-1];

  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    tkls_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .insert     (in_fire),
      .clear_row  (in_data.end_of_set),
      .sample     (in_data.sample_value),
      .link_in    (links[i]),
      .link_out   (links[i+1]),
      .buf_load   (load),
      .buf_shift  (out_fire),
      .buf_in     (bufs[i+1]),
      .buf_out    (bufs[i]),
      .valid_next (nvalid[i]),
      .valid_q    (cell_valid[i])
    );
  end

  // Count results on load, count down as they leave
  always_comb begin
    buf_count_next = buf_count;
    if (load) begin
      buf_count_next = CW'($countones(nvalid));
    end else if (out_fire) begin
      buf_count_next = buf_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= '0;
      rank      <= '0;
    end else begin
      buf_count <= buf_count_next;
      if (load) begin
        rank <= '0;
      end else if (out_fire) begin
        rank <= rank + RANK_W'(1);
      end
    end
  end

  assign out_valid = (buf_count != '0);
  assign out_data  = '{top_value:     bufs[0],
                       rank_position: rank,
                       final_result:  (buf_count == CW'(1))};

  // Held values always fill the chain from the left
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("chain holds a gap");

  // Result count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    buf_count <= CW'(TOP_K))
    else $error("result count out of range");

  // An accepted end of set always yields results next cycle
  a_set_emits: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("end of set produced no result");

  // Final result leaving with no new set empties the line
  a_final_drains: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_data.final_result && !load) |=> !out_valid)
    else $error("results remain after final");

endmodule : top_k_largest_selector

`default_nettype wire
